>>> rtl/core/bct_pkg.sv
// ----------------------------------------------------------------------------
// bct_pkg
// shared types and constants of the binary contour tracer
// ----------------------------------------------------------------------------
package bct_pkg;

    localparam int COORD_W   = 9;
    localparam int COUNT_W   = 17;
    localparam int CFG_W     = 9;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'd65536;

    // commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // headings
    localparam logic [1:0] HD_EAST  = 2'd0;
    localparam logic [1:0] HD_SOUTH = 2'd1;
    localparam logic [1:0] HD_WEST  = 2'd2;
    localparam logic [1:0] HD_NORTH = 2'd3;

    // config register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic img_we;
        logic img_wdata;
        logic mask_we;
        logic mask_wdata;
    } bct_wr_t;

    typedef struct packed {
        logic [COUNT_W-1:0] contour_count;
        logic               no_contour;
        logic               contour_end;
        logic               point_valid;
        logic [COORD_W-1:0] point_y;
        logic [COORD_W-1:0] point_x;
    } bct_res_t;

endpackage

>>> rtl/core/binary_contour_tracer.sv
// ----------------------------------------------------------------------------
// binary_contour_tracer
// traces outer boundaries of a binary image along pixel corners
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid / s_tready  tuser: command; tdata: pixel word
//  m_        out  m_tvalid / m_tready  tuser: flags; tlast: contour end
//  cfg_      in   cfg_wr_en            cfg_addr, cfg_wr_data
//
//  write and unknown commands go straight to the result; a step does its two image
//  reads together, then the mask write and move; a start reads the mask in raster
//  order until it finds its pixel, and an empty scan reads all width * height
//  pixels before it reports
//  image and mask memories are not cleared by reset; no clearing pass
//  a stalled result waits in the output register while the next word is taken
// ----------------------------------------------------------------------------
module binary_contour_tracer #(
    parameter int MAX_WIDTH  = bct_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bct_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pixel_x[8:0], pixel_y[17:9], pixel_black[18], mask_set[19], zero fill
    input  logic [bct_pkg::S_TDATA_W-1:0] s_tdata,
    // command[1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // point_x[8:0], point_y[17:9], contour_count[34:18], zero fill
    output logic [bct_pkg::M_TDATA_W-1:0] m_tdata,
    // point_valid[0], no_contour[1]
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [bct_pkg::CFG_W-1:0]     cfg_wr_data
);

    localparam int ADDR_W = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);
    localparam int CW     = bct_pkg::COORD_W;

    localparam logic [CW-1:0] WIDTH_RST  = (256 > MAX_WIDTH)  ? CW'(MAX_WIDTH)  : CW'(256);
    localparam logic [CW-1:0] HEIGHT_RST = (256 > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(256);

    logic [CW-1:0] width_reg, width_next, height_reg, height_next;
    logic [CW-1:0] w_clamp, h_clamp;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [bct_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]                   m_tuser_reg, m_tuser_next;
    logic                         m_tlast_reg, m_tlast_next;

    logic                  res_valid, res_ready;
    bct_pkg::bct_res_t     res;
    bct_pkg::bct_wr_t      wr;
    logic [ADDR_W-1:0]     wr_addr, img_raddr_a, img_raddr_b, mask_raddr;
    logic                  img_rdata_a, img_rdata_b, mask_rdata;

    // register clamp: zero reads as one, saturate at the maximum
    always_comb begin
        priority if (cfg_wr_data == '0) begin
            w_clamp = CW'(1);
        end else if (32'(cfg_wr_data) > MAX_WIDTH) begin
            w_clamp = CW'(MAX_WIDTH);
        end else begin
            w_clamp = cfg_wr_data;
        end
        priority if (cfg_wr_data == '0) begin
            h_clamp = CW'(1);
        end else if (32'(cfg_wr_data) > MAX_HEIGHT) begin
            h_clamp = CW'(MAX_HEIGHT);
        end else begin
            h_clamp = cfg_wr_data;
        end
    end

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                bct_pkg::CFG_WIDTH:  width_next  = w_clamp;
                bct_pkg::CFG_HEIGHT: height_next = h_clamp;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // output word register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = bct_pkg::M_TDATA_W'({res.contour_count, res.point_y, res.point_x});
            m_tuser_next  = {res.no_contour, res.point_valid};
            m_tlast_next  = res.contour_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    bct_pixel_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk        (aclk),
        .wr          (wr),
        .wr_addr     (wr_addr),
        .img_raddr_a (img_raddr_a),
        .img_raddr_b (img_raddr_b),
        .mask_raddr  (mask_raddr),
        .img_rdata_a (img_rdata_a),
        .img_rdata_b (img_rdata_b),
        .mask_rdata  (mask_rdata)
    );

    bct_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .width_cfg   (width_reg),
        .height_cfg  (height_reg),
        .item_valid  (s_tvalid),
        .item_ready  (s_tready),
        .item_cmd    (s_tuser),
        .item_x      (s_tdata[8:0]),
        .item_y      (s_tdata[17:9]),
        .item_black  (s_tdata[18]),
        .item_mask   (s_tdata[19]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .wr          (wr),
        .wr_addr     (wr_addr),
        .img_raddr_a (img_raddr_a),
        .img_raddr_b (img_raddr_b),
        .mask_raddr  (mask_raddr),
        .img_rdata_a (img_rdata_a),
        .img_rdata_b (img_rdata_b),
        .mask_rdata  (mask_rdata)
    );

endmodule

>>> rtl/core/bct_pixel_mem.sv
// ----------------------------------------------------------------------------
// bct_pixel_mem
// image and start-mask bit memories, one write port, registered reads
// ----------------------------------------------------------------------------
module bct_pixel_mem #(
    parameter int ADDR_W = 16
) (
    input  logic                aclk,
    input  bct_pkg::bct_wr_t    wr,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  logic [ADDR_W-1:0]   img_raddr_a,
    input  logic [ADDR_W-1:0]   img_raddr_b,
    input  logic [ADDR_W-1:0]   mask_raddr,
    output logic                img_rdata_a,
    output logic                img_rdata_b,
    output logic                mask_rdata
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic img_mem  [DEPTH];
    logic mask_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.img_we) begin
            img_mem[wr_addr] <= wr.img_wdata;
        end
        img_rdata_a <= img_mem[img_raddr_a];
        img_rdata_b <= img_mem[img_raddr_b];
    end

    always_ff @(posedge aclk) begin
        if (wr.mask_we) begin
            mask_mem[wr_addr] <= wr.mask_wdata;
        end
        mask_rdata <= mask_mem[mask_raddr];
    end

endmodule

>>> rtl/core/bct_ctrl.sv
// ----------------------------------------------------------------------------
// bct_ctrl
// command sequencer: pixel writes, raster mask scan and boundary steps
// ----------------------------------------------------------------------------
module bct_ctrl #(
    parameter int MAX_WIDTH  = bct_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bct_pkg::DEF_MAX_HEIGHT,
    parameter int ADDR_W     = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [bct_pkg::COORD_W-1:0] width_cfg,
    input  logic [bct_pkg::COORD_W-1:0] height_cfg,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic [1:0]                  item_cmd,
    input  logic [bct_pkg::COORD_W-1:0] item_x,
    input  logic [bct_pkg::COORD_W-1:0] item_y,
    input  logic                        item_black,
    input  logic                        item_mask,
    output logic                        res_valid,
    input  logic                        res_ready,
    output bct_pkg::bct_res_t           res,
    output bct_pkg::bct_wr_t            wr,
    output logic [ADDR_W-1:0]           wr_addr,
    output logic [ADDR_W-1:0]           img_raddr_a,
    output logic [ADDR_W-1:0]           img_raddr_b,
    output logic [ADDR_W-1:0]           mask_raddr,
    input  logic                        img_rdata_a,
    input  logic                        img_rdata_b,
    input  logic                        mask_rdata
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int CW    = bct_pkg::COORD_W;
    localparam int PW    = CW + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_EXE  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]                   state_reg, state_next;
    logic [CW-1:0]                cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [CW-1:0]                head_x_reg, head_x_next, head_y_reg, head_y_next;
    logic [1:0]                   hd_reg, hd_next;
    logic                         tracing_reg, tracing_next;
    logic [bct_pkg::COUNT_W-1:0]  tot_reg, tot_next;
    logic [CW-1:0]                sx_reg, sx_next, sy_reg, sy_next;
    logic                         issue_done_reg, issue_done_next;
    logic                         chk_valid_reg, chk_valid_next;
    logic [CW-1:0]                chk_x_reg, chk_x_next, chk_y_reg, chk_y_next;
    logic                         l_in_reg, l_in_next, r_in_reg, r_in_next;
    logic [CW-1:0]                pt_x_reg, pt_x_next, pt_y_reg, pt_y_next;
    logic                         pt_vld_reg, pt_vld_next;
    logic                         end_reg, end_next;
    logic                         none_reg, none_next;

    logic          accept;
    logic          hit;
    logic [PW-1:0] x0, y0, x1, y1;
    logic [PW-1:0] lx, ly, rx, ry;
    logic          pg, pd;
    logic [1:0]    new_hd;
    logic [CW-1:0] nx, ny;
    logic          wr_in_range;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [PW-1:0] col0,
                                                     input logic [PW-1:0] row0);
        logic [COL_W+PW-1:0] cx;
        logic [ROW_W+PW-1:0] ry_w;
        cx   = (COL_W + PW)'(col0);
        ry_w = (ROW_W + PW)'(row0);
        return {ry_w[ROW_W-1:0], cx[COL_W-1:0]};
    endfunction

    function automatic logic in_image(input logic [PW-1:0] px, input logic [PW-1:0] py,
                                      input logic [CW-1:0] w, input logic [CW-1:0] h);
        return (px != '0) && (py != '0) && (px <= {1'b0, w}) && (py <= {1'b0, h});
    endfunction

    assign accept     = item_valid && item_ready;
    assign item_ready = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_EMIT);
    assign hit        = chk_valid_reg && mask_rdata;

    assign x0 = {1'b0, cur_x_reg};
    assign y0 = {1'b0, cur_y_reg};
    assign x1 = x0 + PW'(1);
    assign y1 = y0 + PW'(1);

    // pixels ahead, left and right of the heading, 1-based
    always_comb begin
        unique case (hd_reg)
            bct_pkg::HD_EAST:  begin lx = x1; ly = y0; rx = x1; ry = y1; end
            bct_pkg::HD_SOUTH: begin lx = x1; ly = y1; rx = x0; ry = y1; end
            bct_pkg::HD_WEST:  begin lx = x0; ly = y1; rx = x0; ry = y0; end
            default:           begin lx = x0; ly = y0; rx = x1; ry = y0; end
        endcase
    end

    assign pg = l_in_reg && img_rdata_a;
    assign pd = r_in_reg && img_rdata_b;

    always_comb begin
        priority if (!pg && !pd) begin
            new_hd = hd_reg + 2'd1;
        end else if (pg) begin
            new_hd = hd_reg - 2'd1;
        end else begin
            new_hd = hd_reg;
        end
    end

    always_comb begin
        nx = cur_x_reg;
        ny = cur_y_reg;
        unique case (new_hd)
            bct_pkg::HD_EAST:  nx = cur_x_reg + CW'(1);
            bct_pkg::HD_SOUTH: ny = cur_y_reg + CW'(1);
            bct_pkg::HD_WEST:  nx = cur_x_reg - CW'(1);
            default:           ny = cur_y_reg - CW'(1);
        endcase
    end

    assign wr_in_range = (item_x != '0) && (item_y != '0)
                      && (32'(item_x) <= MAX_WIDTH) && (32'(item_y) <= MAX_HEIGHT);

    always_comb begin
        state_next      = state_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        head_x_next     = head_x_reg;
        head_y_next     = head_y_reg;
        hd_next         = hd_reg;
        tracing_next    = tracing_reg;
        tot_next        = tot_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        issue_done_next = issue_done_reg;
        chk_valid_next  = 1'b0;
        chk_x_next      = sx_reg;
        chk_y_next      = sy_reg;
        l_in_next       = l_in_reg;
        r_in_next       = r_in_reg;
        pt_x_next       = pt_x_reg;
        pt_y_next       = pt_y_reg;
        pt_vld_next     = pt_vld_reg;
        end_next        = end_reg;
        none_next       = none_reg;
        wr              = '0;
        wr_addr         = '0;
        img_raddr_a     = '0;
        img_raddr_b     = '0;
        mask_raddr      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    pt_x_next   = '0;
                    pt_y_next   = '0;
                    pt_vld_next = 1'b0;
                    end_next    = 1'b0;
                    none_next   = 1'b0;
                    state_next  = ST_EMIT;
                    unique case (item_cmd)
                        bct_pkg::CMD_WRITE: begin
                            if (wr_in_range) begin
                                wr.img_we      = 1'b1;
                                wr.img_wdata   = item_black;
                                wr.mask_we     = 1'b1;
                                wr.mask_wdata  = item_mask;
                                wr_addr = cell_addr({1'b0, item_x} - PW'(1),
                                                    {1'b0, item_y} - PW'(1));
                            end
                        end
                        bct_pkg::CMD_START: begin
                            sx_next         = '0;
                            sy_next         = '0;
                            issue_done_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        bct_pkg::CMD_STEP: begin
                            if (tracing_reg) begin
                                state_next = ST_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                priority if (hit) begin
                    wr.mask_we   = 1'b1;
                    wr.mask_wdata = 1'b0;
                    wr_addr      = cell_addr({1'b0, chk_x_reg}, {1'b0, chk_y_reg});
                    head_x_next  = chk_x_reg;
                    head_y_next  = chk_y_reg;
                    cur_x_next   = chk_x_reg;
                    cur_y_next   = chk_y_reg;
                    hd_next      = bct_pkg::HD_EAST;
                    tracing_next = 1'b1;
                    if (tot_reg < bct_pkg::COUNT_MAX) begin
                        tot_next = tot_reg + bct_pkg::COUNT_W'(1);
                    end
                    pt_x_next    = chk_x_reg;
                    pt_y_next    = chk_y_reg;
                    pt_vld_next  = 1'b1;
                    state_next   = ST_EMIT;
                end else if (issue_done_reg && !chk_valid_reg) begin
                    tracing_next = 1'b0;
                    none_next    = 1'b1;
                    state_next   = ST_EMIT;
                end else if (!issue_done_reg) begin
                    mask_raddr     = cell_addr({1'b0, sx_reg}, {1'b0, sy_reg});
                    chk_valid_next = 1'b1;
                    if (sx_reg == width_cfg - CW'(1)) begin
                        sx_next = '0;
                        if (sy_reg == height_cfg - CW'(1)) begin
                            issue_done_next = 1'b1;
                        end else begin
                            sy_next = sy_reg + CW'(1);
                        end
                    end else begin
                        sx_next = sx_reg + CW'(1);
                    end
                end else begin
                    chk_valid_next = 1'b0;
                end
            end

            ST_RD: begin
                img_raddr_a = cell_addr(lx - PW'(1), ly - PW'(1));
                img_raddr_b = cell_addr(rx - PW'(1), ry - PW'(1));
                l_in_next   = in_image(lx, ly, width_cfg, height_cfg);
                r_in_next   = in_image(rx, ry, width_cfg, height_cfg);
                state_next  = ST_EXE;
            end

            ST_EXE: begin
                hd_next = new_hd;
                if (new_hd == bct_pkg::HD_EAST && in_image(x1, y1, width_cfg, height_cfg)) begin
                    wr.mask_we    = 1'b1;
                    wr.mask_wdata = 1'b0;
                    wr_addr       = cell_addr(x0, y0);
                end
                cur_x_next  = nx;
                cur_y_next  = ny;
                pt_x_next   = nx;
                pt_y_next   = ny;
                pt_vld_next = 1'b1;
                if (nx == head_x_reg && ny == head_y_reg) begin
                    end_next     = 1'b1;
                    tracing_next = 1'b0;
                end
                state_next = ST_EMIT;
            end

            ST_EMIT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            head_x_reg    <= '0;
            head_y_reg    <= '0;
            hd_reg        <= bct_pkg::HD_EAST;
            tracing_reg   <= 1'b0;
            tot_reg       <= '0;
            chk_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            head_x_reg    <= head_x_next;
            head_y_reg    <= head_y_next;
            hd_reg        <= hd_next;
            tracing_reg   <= tracing_next;
            tot_reg       <= tot_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sx_reg         <= sx_next;
        sy_reg         <= sy_next;
        issue_done_reg <= issue_done_next;
        chk_x_reg      <= chk_x_next;
        chk_y_reg      <= chk_y_next;
        l_in_reg       <= l_in_next;
        r_in_reg       <= r_in_next;
        pt_x_reg       <= pt_x_next;
        pt_y_reg       <= pt_y_next;
        pt_vld_reg     <= pt_vld_next;
        end_reg        <= end_next;
        none_reg       <= none_next;
    end

    always_comb begin
        res.point_x       = pt_x_reg;
        res.point_y       = pt_y_reg;
        res.point_valid   = pt_vld_reg;
        res.contour_end   = end_reg;
        res.no_contour    = none_reg;
        res.contour_count = tot_reg;
    end

    // mask clears during a step only on an eastward move
    a_step_clear_east: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXE && wr.mask_we) |-> (new_hd == bct_pkg::HD_EAST))
        else $error("mask cleared on a non-east step");

    // contour count only moves on a scan hit
    a_count_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && tot_reg != $past(tot_reg))
            |-> ($past(state_reg == ST_SCAN) && $past(hit)))
        else $error("contour count changed without a scan hit");

    // exhausted scan reports at once
    a_scan_exhaust: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && issue_done_reg && !chk_valid_reg)
            |=> (state_reg == ST_EMIT && none_reg))
        else $error("exhausted scan did not report no contour");

    // a result word never carries both a point and a failed scan
    a_res_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !(res.point_valid && res.no_contour))
        else $error("result flags point and no contour together");

endmodule

>>> tb/binary_contour_tracer_tb.sv
// ----------------------------------------------------------------------------
// binary_contour_tracer_tb
// self-checking bench for the binary contour tracer: a directed table walks
// reset values, ignored writes, one-pixel and two-by-two images and corner
// wrap, then random images of several sizes are loaded and traced, with every
// result word compared against an in-bench tracer under random bursts, gaps
// and receiver stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_contour_tracer_tb;

    localparam int MAX_W = bct_pkg::DEF_MAX_WIDTH;
    localparam int MAX_H = bct_pkg::DEF_MAX_HEIGHT;
    localparam int CW    = bct_pkg::COORD_W;
    localparam int NW    = bct_pkg::COUNT_W;
    localparam int GW    = bct_pkg::CFG_W;
    localparam int unsigned LIMIT = 600000;

    typedef struct packed {
        logic                is_reg;
        logic                reg_sel;
        logic [GW-1:0]       reg_val;
        logic [1:0]          cmd;
        logic [CW-1:0]       px;
        logic [CW-1:0]       py;
        logic                blk;
        logic                msk;
        logic                typed;
        bct_pkg::bct_res_t   want;
    } dir_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [bct_pkg::S_TDATA_W-1:0] s_tdata;
    logic [1:0]                    s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [bct_pkg::M_TDATA_W-1:0] m_tdata;
    logic [1:0]                    m_tuser;
    logic                          m_tlast;
    logic                          cfg_wr_en;
    logic                          cfg_addr;
    logic [GW-1:0]                 cfg_wr_data;

    // tracer state
    bit                   img_bits  [0:MAX_W*MAX_H-1];
    bit                   mask_bits [0:MAX_W*MAX_H-1];
    int                   cfg_width  = MAX_W;
    int                   cfg_height = MAX_H;
    logic [CW-1:0]        walk_x, walk_y, head_x, head_y;
    logic [1:0]           walk_dir;
    bit                   tracing;
    logic [NW-1:0]        n_contours;

    bct_pkg::bct_res_t    pending_pts [$];
    dir_row_t             dir_rows [$];

    int unsigned          cycle_cnt = 0;
    int                   fail_cnt = 0;
    int                   words_sent = 0;
    int                   results_seen = 0;
    int                   closed_cnt = 0;
    int                   empty_scans = 0;
    int                   hold_cnt = 0;
    int                   burst_left = 0;
    bit                   hold_req = 0;

    binary_contour_tracer uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= LIMIT);
        $display("[binary_contour_tracer] ERROR");
        $finish;
    end

    function automatic bit in_area(int px, int py);
        return px >= 1 && py >= 1 && px <= cfg_width && py <= cfg_height;
    endfunction

    function automatic bit pix_black(int px, int py);
        return in_area(px, py) && img_bits[(py - 1) * MAX_W + px - 1];
    endfunction

    function automatic bct_pkg::bct_res_t res_of(int x, int y, logic vld, logic cend,
                                                 logic none, int cnt);
        bct_pkg::bct_res_t r;
        r.point_x       = CW'(x);
        r.point_y       = CW'(y);
        r.point_valid   = vld;
        r.contour_end   = cend;
        r.no_contour    = none;
        r.contour_count = NW'(cnt);
        return r;
    endfunction

    task automatic trace_predict(input logic [1:0] cmd, input logic [CW-1:0] px, py,
                                 input logic blk, msk, output bct_pkg::bct_res_t r);
        int x, y, lx, ly, rx, ry;
        bit found, pg, pd;
        r = '0;
        found = 0;
        case (cmd)
            bct_pkg::CMD_WRITE: begin
                if (px >= 1 && py >= 1 && px <= MAX_W && py <= MAX_H) begin
                    img_bits[(py - 1) * MAX_W + px - 1]  = blk;
                    mask_bits[(py - 1) * MAX_W + px - 1] = msk;
                end
            end
            bct_pkg::CMD_START: begin
                for (y = 1; y <= cfg_height && !found; y++) begin
                    for (x = 1; x <= cfg_width && !found; x++) begin
                        if (mask_bits[(y - 1) * MAX_W + x - 1]) begin
                            found = 1;
                            mask_bits[(y - 1) * MAX_W + x - 1] = 0;
                            head_x   = CW'(x - 1);
                            head_y   = CW'(y - 1);
                            walk_x   = CW'(x - 1);
                            walk_y   = CW'(y - 1);
                            walk_dir = bct_pkg::HD_EAST;
                            if (n_contours < bct_pkg::COUNT_MAX)
                                n_contours = n_contours + NW'(1);
                            r.point_x     = CW'(x - 1);
                            r.point_y     = CW'(y - 1);
                            r.point_valid = 1'b1;
                        end
                    end
                end
                tracing = found;
                r.no_contour = !found;
            end
            bct_pkg::CMD_STEP: begin
                if (tracing) begin
                    x = int'(walk_x);
                    y = int'(walk_y);
                    case (walk_dir)
                        bct_pkg::HD_EAST: begin
                            lx = x + 1; ly = y;     rx = x + 1; ry = y + 1;
                        end
                        bct_pkg::HD_SOUTH: begin
                            lx = x + 1; ly = y + 1; rx = x;     ry = y + 1;
                        end
                        bct_pkg::HD_WEST: begin
                            lx = x;     ly = y + 1; rx = x;     ry = y;
                        end
                        default: begin
                            lx = x;     ly = y;     rx = x + 1; ry = y;
                        end
                    endcase
                    pg = pix_black(lx, ly);
                    pd = pix_black(rx, ry);
                    if (!pg && !pd) walk_dir = walk_dir + 2'd1;
                    else if (pg) walk_dir = walk_dir + 2'd3;
                    if (walk_dir == bct_pkg::HD_EAST && in_area(x + 1, y + 1))
                        mask_bits[y * MAX_W + x] = 0;
                    case (walk_dir)
                        bct_pkg::HD_EAST:  x = (x + 1) & 511;
                        bct_pkg::HD_SOUTH: y = (y + 1) & 511;
                        bct_pkg::HD_WEST:  x = (x - 1) & 511;
                        default:           y = (y - 1) & 511;
                    endcase
                    walk_x = CW'(x);
                    walk_y = CW'(y);
                    r.point_x     = CW'(x);
                    r.point_y     = CW'(y);
                    r.point_valid = 1'b1;
                    if (walk_x == head_x && walk_y == head_y) begin
                        r.contour_end = 1'b1;
                        tracing = 0;
                    end
                end
            end
            default: ;
        endcase
        r.contour_count = n_contours;
    endtask

    task automatic send_word(input logic [1:0] cmd, input logic [CW-1:0] px, py,
                             input logic blk, msk, input logic typed,
                             input bct_pkg::bct_res_t want);
        bct_pkg::bct_res_t r;
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, msk, blk, py, px};
        do @(posedge aclk); while (!s_tready);
        trace_predict(cmd, px, py, blk, msk, r);
        if (typed) pending_pts.push_back(want);
        else pending_pts.push_back(r);
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? 80 : int'($urandom_range(0, 12));
            gap = int'($urandom_range(0, 6));
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic send_rand(input logic [1:0] cmd);
        send_word(cmd, CW'($urandom_range(0, 511)), CW'($urandom_range(0, 511)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_pts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic sel, input logic [GW-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= sel;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (sel == bct_pkg::CFG_WIDTH)
            cfg_width = (val == 0) ? 1 : ((int'(val) > MAX_W) ? MAX_W : int'(val));
        else
            cfg_height = (val == 0) ? 1 : ((int'(val) > MAX_H) ? MAX_H : int'(val));
        @(posedge aclk);
    endtask

    task automatic add_word(input logic [1:0] cmd, input logic [CW-1:0] px, py,
                            input logic blk, msk, input logic typed,
                            input bct_pkg::bct_res_t want);
        dir_row_t row;
        row = '0;
        row.cmd   = cmd;
        row.px    = px;
        row.py    = py;
        row.blk   = blk;
        row.msk   = msk;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    task automatic add_reg(input logic sel, input logic [GW-1:0] val);
        dir_row_t row;
        row = '0;
        row.is_reg  = 1'b1;
        row.reg_sel = sel;
        row.reg_val = val;
        dir_rows.push_back(row);
    endtask

    task automatic cmp_field(input string name, input logic [NW-1:0] want, got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    task automatic check_point();
        bct_pkg::bct_res_t want;
        if (pending_pts.size() == 0) begin
            $error("result word with nothing expected");
            fail_cnt++;
            return;
        end
        want = pending_pts.pop_front();
        results_seen++;
        cmp_field("point_x", NW'(want.point_x), NW'(m_tdata[8:0]));
        cmp_field("point_y", NW'(want.point_y), NW'(m_tdata[17:9]));
        cmp_field("contour_count", want.contour_count, m_tdata[34:18]);
        cmp_field("point_valid", NW'(want.point_valid), NW'(m_tuser[0]));
        cmp_field("no_contour", NW'(want.no_contour), NW'(m_tuser[1]));
        cmp_field("contour_end", NW'(want.contour_end), NW'(m_tlast));
        if (m_tlast === 1'b1) closed_cnt++;
        if (m_tuser[1] === 1'b1) empty_scans++;
    endtask

    // result sink with its own stall pattern and long hold-offs
    initial begin
        int hold_left;
        int rs_mode;
        int rs_cnt;
        logic rdy;
        hold_left = 0;
        rs_mode   = 0;
        rs_cnt    = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) check_point();
            if (hold_req && hold_left == 0) begin
                hold_req  = 0;
                hold_left = 400;
                hold_cnt++;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (rs_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 3) != 0);
                    2:       rdy = ((rs_cnt % 7) >= 3);
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            rs_cnt++;
            if (rs_cnt % 128 == 0) rs_mode = int'($urandom_range(0, 3));
            m_tready <= rdy;
        end
    end

    initial begin
        bct_pkg::bct_res_t zero_pt;
        int ph, x, y, pw, phh, dens, n_trace, pick, cap, n_steps;
        logic blk, msk;

        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= bct_pkg::CMD_NONE;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= bct_pkg::CFG_WIDTH;
        cfg_wr_data <= '0;
        aresetn     <= 1'b0;
        walk_x = '0; walk_y = '0; head_x = '0; head_y = '0;
        walk_dir = bct_pkg::HD_EAST; tracing = 0; n_contours = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset size, no reads of unwritten pixels
        zero_pt = res_of(0, 0, 1'b0, 1'b0, 1'b0, 0);
        add_word(bct_pkg::CMD_STEP,  9'd0,   9'd0,   1'b0, 1'b0, 1'b1, zero_pt);
        add_word(bct_pkg::CMD_NONE,  9'd511, 9'd511, 1'b1, 1'b1, 1'b1, zero_pt);
        add_word(bct_pkg::CMD_WRITE, 9'd0,   9'd9,   1'b1, 1'b1, 1'b1, zero_pt);
        add_word(bct_pkg::CMD_WRITE, 9'd511, 9'd256, 1'b1, 1'b1, 1'b1, zero_pt);
        add_word(bct_pkg::CMD_WRITE, 9'd256, 9'd256, 1'b1, 1'b1, 1'b1, zero_pt);
        // zero registers give a single pixel
        add_reg(bct_pkg::CFG_WIDTH, 9'd0);
        add_reg(bct_pkg::CFG_HEIGHT, 9'd0);
        add_word(bct_pkg::CMD_WRITE, 9'd1, 9'd1, 1'b1, 1'b1, 1'b1, zero_pt);
        add_word(bct_pkg::CMD_START, 9'd7, 9'd3, 1'b1, 1'b0, 1'b1,
                 res_of(0, 0, 1'b1, 1'b0, 1'b0, 1));
        repeat (4) add_word(bct_pkg::CMD_STEP, 9'd0, 9'd0, 1'b0, 1'b0, 1'b0, '0);
        add_word(bct_pkg::CMD_START, 9'd0, 9'd0, 1'b0, 1'b0, 1'b1,
                 res_of(0, 0, 1'b0, 1'b0, 1'b1, 1));
        // white start pixel walks off the left edge and wraps
        add_word(bct_pkg::CMD_WRITE, 9'd1, 9'd1, 1'b0, 1'b1, 1'b1,
                 res_of(0, 0, 1'b0, 1'b0, 1'b0, 1));
        add_word(bct_pkg::CMD_START, 9'd0, 9'd0, 1'b0, 1'b0, 1'b1,
                 res_of(0, 0, 1'b1, 1'b0, 1'b0, 2));
        repeat (4) add_word(bct_pkg::CMD_STEP, 9'd0, 9'd0, 1'b0, 1'b0, 1'b0, '0);
        // two by two, abandoned contour
        add_reg(bct_pkg::CFG_WIDTH, 9'd2);
        add_reg(bct_pkg::CFG_HEIGHT, 9'd2);
        add_word(bct_pkg::CMD_WRITE, 9'd1, 9'd1, 1'b0, 1'b0, 1'b0, '0);
        add_word(bct_pkg::CMD_WRITE, 9'd2, 9'd1, 1'b1, 1'b1, 1'b0, '0);
        add_word(bct_pkg::CMD_WRITE, 9'd1, 9'd2, 1'b1, 1'b0, 1'b0, '0);
        add_word(bct_pkg::CMD_WRITE, 9'd2, 9'd2, 1'b1, 1'b1, 1'b0, '0);
        add_word(bct_pkg::CMD_START, 9'd0, 9'd0, 1'b0, 1'b0, 1'b0, '0);
        add_word(bct_pkg::CMD_STEP,  9'd0, 9'd0, 1'b0, 1'b0, 1'b0, '0);
        add_word(bct_pkg::CMD_START, 9'd0, 9'd0, 1'b0, 1'b0, 1'b0, '0);
        add_word(bct_pkg::CMD_STEP,  9'd0, 9'd0, 1'b0, 1'b0, 1'b0, '0);
        add_word(bct_pkg::CMD_NONE,  9'd3, 9'd3, 1'b1, 1'b1, 1'b0, '0);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_reg) begin
                settle();
                write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
            end else begin
                send_word(dir_rows[i].cmd, dir_rows[i].px, dir_rows[i].py, dir_rows[i].blk,
                          dir_rows[i].msk, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       begin pw = 8;   phh = 8;   end
                1:       begin pw = 300; phh = 1;   end
                2:       begin pw = 12;  phh = 5;   end
                3:       begin pw = 1;   phh = 511; end
                4:       begin pw = 6;   phh = 10;  end
                5:       begin pw = 16;  phh = 8;   end
                6:       begin pw = 4;   phh = 4;   end
                default: begin pw = 256; phh = 1;   end
            endcase
            settle();
            write_reg(bct_pkg::CFG_WIDTH, GW'(pw));
            write_reg(bct_pkg::CFG_HEIGHT, GW'(phh));

            // load every pixel in use before anything reads it
            dens = int'($urandom_range(25, 65));
            for (y = 1; y <= cfg_height; y++) begin
                for (x = 1; x <= cfg_width; x++) begin
                    blk = ($urandom_range(0, 99) < dens);
                    msk = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : blk;
                    send_word(bct_pkg::CMD_WRITE, CW'(x), CW'(y), blk, msk, 1'b0, '0);
                    if ($urandom_range(0, 19) == 0) send_rand(bct_pkg::CMD_WRITE);
                end
            end

            if (ph == 2 || ph == 5) hold_req = 1;
            n_trace = 0;
            while (n_trace < 16) begin
                pick = int'($urandom_range(0, 19));
                if (pick == 0) begin
                    send_rand(bct_pkg::CMD_NONE);
                    n_trace++;
                end else if (pick == 1) begin
                    send_rand(bct_pkg::CMD_STEP);
                    n_trace++;
                end else if (pick == 2) begin
                    send_word(bct_pkg::CMD_WRITE, CW'($urandom_range(1, cfg_width)),
                              CW'($urandom_range(1, cfg_height)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'b0, '0);
                    n_trace++;
                end else begin
                    send_rand(bct_pkg::CMD_START);
                    n_trace++;
                    cap = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 6)) : 400;
                    n_steps = 0;
                    while (tracing && n_steps < cap) begin
                        send_rand(bct_pkg::CMD_STEP);
                        n_steps++;
                        n_trace++;
                    end
                end
            end
        end

        settle();
        repeat (40) @(posedge aclk);
        if (pending_pts.size() != 0) begin
            $error("%0d result words never arrived", pending_pts.size());
            fail_cnt++;
        end
        $display("covered %0d words over 11 image sizes, %0d result words checked",
                 words_sent, results_seen);
        $display("%0d contours closed, %0d empty scans, %0d long receiver hold-offs",
                 closed_cnt, empty_scans, hold_cnt);
        if (fail_cnt == 0) begin
            $display("[binary_contour_tracer] OK");
        end else begin
            $display("[binary_contour_tracer] ERROR");
        end
        $finish;
    end

endmodule
